### rtl/core/complex_boxcar_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex boxcar moving average
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_BOXCAR_MOVING_AVERAGE_ASSERT_SVH
`define COMPLEX_BOXCAR_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication
`define CBMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CBMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cbma_pkg.sv
// ----------------------------------------------------------------------------
// cbma_pkg
// Fixed constants of the complex boxcar moving average: register map and
// configuration field widths.
// ----------------------------------------------------------------------------
package cbma_pkg;

  // APB register file
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index decoded from the word address bit
  localparam logic REG_WIN_LEN = 1'b0;

  // Width of the window length register
  localparam int WIN_W = 7;

endpackage

### rtl/core/complex_boxcar_moving_average.sv
// ----------------------------------------------------------------------------
// complex_boxcar_moving_average
// Top level: APB window register, delay-line memory, running sums, mean
// divider and result sequencer.
// ----------------------------------------------------------------------------
// Complex boxcar moving average over finite signals. Samples arrive one at a
// time with the last sample of a signal flagged on in_tlast. Once a full
// window of samples of the current signal has arrived, each sample yields the
// window mean of both parts (truncated toward zero); the last sample's mean is
// then repeated so a signal of n samples gives n results, the last one marked
// on out_tlast. A signal that ends before the window fills gives one zero
// result with out_tuser (too short) and out_tlast set. The block handles one
// sample at a time: in_tready stays low from the acceptance of a sample until
// its sums are updated or, where it yields results, until the last of them is
// taken, and each window mean comes from the one-bit-per-cycle mean divider.
// Writing the window length register clears the signal state and must happen
// between signals.
`include "complex_boxcar_moving_average_assert.svh"

module complex_boxcar_moving_average #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Sample stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tdata: sample_re, sample_im, zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // tlast: end_of_signal
  input  logic                         in_tlast,
  // Result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // tdata: avg_re, avg_im, zero pad
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  // tlast: final_result
  output logic                         out_tlast,
  // tuser: too_short
  output logic                         out_tuser,
  // Configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cbma_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cbma_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cbma_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  import cbma_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = ((2*SW+7)/8)*8;
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SW + CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [WIN_W-1:0]        win_r;
  logic [CNT_W-1:0]        win_eff;
  logic signed [SUM_W-1:0] sum_re_r, sum_re_nxt;
  logic signed [SUM_W-1:0] sum_im_r, sum_im_nxt;
  logic [CNT_W-1:0]        seen_r, seen_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic                    sub_r;
  logic [SW-1:0]           smp_re_r, smp_im_r;
  logic                    last_r;
  logic                    div_go_r, div_go_nxt;
  logic [CNT_W-1:0]        rep_left_r, rep_left_nxt;
  logic [SW-1:0]           avg_re_r, avg_re_nxt;
  logic [SW-1:0]           avg_im_r, avg_im_nxt;
  logic                    fin_r, fin_nxt;
  logic                    short_r, short_nxt;

  logic                    in_acc, out_acc, cfg_wr;
  logic [CNT_W-1:0]        rd_ofs;
  logic [AW-1:0]           rd_addr;
  logic [2*SW-1:0]         rd_data;
  logic signed [SUM_W-1:0] old_re, old_im, new_re, new_im;
  logic                    have;
  logic                    div_done;
  logic signed [SUM_W-1:0] quo_re, quo_im;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                   && (cfg_paddr[2] == REG_WIN_LEN);

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WIN_LEN) ? CFG_DW'(win_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_W'(1);
    end else if (cfg_wr) begin
      win_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  // Clamp the window to 1..MAX_WINDOW
  always_comb begin
    if (win_r == '0) begin
      win_eff = CNT_W'(1);
    end else if ({1'b0, win_r} > (WIN_W+1)'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(win_r);
    end
  end

  // Oldest sample in the window sits win_eff entries behind the write pointer
  assign rd_ofs  = (CNT_W'(wp_r) >= win_eff) ? (CNT_W'(wp_r) - win_eff)
                   : (CNT_W'(wp_r) + CNT_W'(MAX_WINDOW) - win_eff);
  assign rd_addr = rd_ofs[AW-1:0];

  cbma_hist_mem #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW),
    .DW    (2*SW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data ({in_tdata[2*SW-1:SW], in_tdata[SW-1:0]}),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign old_re = SUM_W'(signed'(rd_data[SW-1:0]));
  assign old_im = SUM_W'(signed'(rd_data[2*SW-1:SW]));
  assign new_re = SUM_W'(signed'(smp_re_r));
  assign new_im = SUM_W'(signed'(smp_im_r));
  assign have   = (seen_r >= win_eff);

  cbma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_go_r),
    .num_re (sum_re_r),
    .num_im (sum_im_r),
    .den    (win_eff),
    .done   (div_done),
    .quo_re (quo_re),
    .quo_im (quo_im)
  );

  // Sequencer: accept, update sums, divide, deliver results
  always_comb begin
    state_nxt    = state_r;
    sum_re_nxt   = sum_re_r;
    sum_im_nxt   = sum_im_r;
    seen_nxt     = seen_r;
    wp_nxt       = wp_r;
    div_go_nxt   = 1'b0;
    rep_left_nxt = rep_left_r;
    avg_re_nxt   = avg_re_r;
    avg_im_nxt   = avg_im_r;
    fin_nxt      = fin_r;
    short_nxt    = short_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wp_nxt    = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
          seen_nxt  = (seen_r < CNT_W'(MAX_WINDOW)) ? seen_r + CNT_W'(1) : seen_r;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_re_nxt = sum_re_r - (sub_r ? old_re : '0) + new_re;
        sum_im_nxt = sum_im_r - (sub_r ? old_im : '0) + new_im;
        if (have) begin
          div_go_nxt = 1'b1;
          state_nxt  = ST_DIV;
        end else if (last_r) begin
          avg_re_nxt   = '0;
          avg_im_nxt   = '0;
          fin_nxt      = 1'b1;
          short_nxt    = 1'b1;
          rep_left_nxt = '0;
          sum_re_nxt   = '0;
          sum_im_nxt   = '0;
          seen_nxt     = '0;
          wp_nxt       = '0;
          state_nxt    = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_re_nxt   = quo_re[SW-1:0];
          avg_im_nxt   = quo_im[SW-1:0];
          short_nxt    = 1'b0;
          fin_nxt      = last_r && (win_eff == CNT_W'(1));
          rep_left_nxt = last_r ? (win_eff - CNT_W'(1)) : '0;
          if (last_r) begin
            sum_re_nxt = '0;
            sum_im_nxt = '0;
            seen_nxt   = '0;
            wp_nxt     = '0;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (rep_left_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rep_left_nxt = rep_left_r - CNT_W'(1);
            fin_nxt      = (rep_left_r == CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A window write starts a new signal
    if (cfg_wr) begin
      sum_re_nxt = '0;
      sum_im_nxt = '0;
      seen_nxt   = '0;
      wp_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sum_re_r   <= '0;
      sum_im_r   <= '0;
      seen_r     <= '0;
      wp_r       <= '0;
      div_go_r   <= 1'b0;
      rep_left_r <= '0;
    end else begin
      state_r    <= state_nxt;
      sum_re_r   <= sum_re_nxt;
      sum_im_r   <= sum_im_nxt;
      seen_r     <= seen_nxt;
      wp_r       <= wp_nxt;
      div_go_r   <= div_go_nxt;
      rep_left_r <= rep_left_nxt;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_re_r <= in_tdata[SW-1:0];
      smp_im_r <= in_tdata[2*SW-1:SW];
      last_r   <= in_tlast;
      sub_r    <= (seen_r >= win_eff);
    end
    avg_re_r <= avg_re_nxt;
    avg_im_r <= avg_im_nxt;
    fin_r    <= fin_nxt;
    short_r  <= short_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = DW'({avg_im_r, avg_re_r});
  assign out_tlast  = fin_r;
  assign out_tuser  = short_r;

  `CBMA_ASSERT_IMP(a_done_in_div, div_done, state_r == ST_DIV, "divider finished outside divide state")
  `CBMA_ASSERT_IMP(a_short_is_zero, out_tvalid && out_tuser, out_tlast && (out_tdata == '0), "too-short result not final or not zero")
  `CBMA_ASSERT_IMP(a_final_no_repeat, out_tvalid && out_tlast, rep_left_r == '0, "final result with repeats pending")

endmodule

### rtl/core/cbma_hist_mem.sv
// ----------------------------------------------------------------------------
// cbma_hist_mem
// Sample delay line: one write port, one registered read port with
// read-first behavior when both ports hit the same entry.
// ----------------------------------------------------------------------------
module cbma_hist_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Read old contents before a write to the same entry lands
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/cbma_div.sv
// ----------------------------------------------------------------------------
// cbma_div
// Two-lane iterative signed divider. Restoring division on magnitudes, one
// quotient bit per lane per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
`include "complex_boxcar_moving_average_assert.svh"

module cbma_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num_re,
  input  logic signed [NUM_W-1:0] num_im,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo_re,
  output logic signed [NUM_W-1:0] quo_im
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r  [2];
  logic             neg_nxt[2];
  logic [NUM_W-1:0] qr_r   [2];
  logic [NUM_W-1:0] qr_nxt [2];
  logic [DEN_W-1:0] rem_r  [2];
  logic [DEN_W-1:0] rem_nxt[2];

  logic signed [NUM_W-1:0] num_sel[2];
  logic [NUM_W-1:0]        quo_mag[2];

  // Load magnitudes on start, then shift one bit through each lane per cycle
  always_comb begin
    logic [DEN_W:0] rem_sh;
    logic           ge;
    rem_sh     = '0;
    ge         = 1'b0;
    num_sel[0] = num_re;
    num_sel[1] = num_im;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    den_nxt    = den_r;
    for (int i = 0; i < 2; i++) begin
      neg_nxt[i] = neg_r[i];
      qr_nxt[i]  = qr_r[i];
      rem_nxt[i] = rem_r[i];
    end
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      den_nxt  = den;
      for (int i = 0; i < 2; i++) begin
        neg_nxt[i] = num_sel[i][NUM_W-1];
        qr_nxt[i]  = num_sel[i][NUM_W-1] ? (~num_sel[i] + NUM_W'(1)) : num_sel[i];
        rem_nxt[i] = '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        rem_sh     = {rem_r[i], qr_r[i][NUM_W-1]};
        ge         = (rem_sh >= {1'b0, den_r});
        rem_nxt[i] = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        qr_nxt[i]  = {qr_r[i][NUM_W-2:0], ge};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    for (int i = 0; i < 2; i++) begin
      neg_r[i] <= neg_nxt[i];
      qr_r[i]  <= qr_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

  // Restore the sign of each quotient
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      quo_mag[i] = neg_r[i] ? (~qr_r[i] + NUM_W'(1)) : qr_r[i];
    end
  end

  assign done   = done_r;
  assign quo_re = signed'(quo_mag[0]);
  assign quo_im = signed'(quo_mag[1]);

  `CBMA_ASSERT_NXT(a_div_done_pulse, done_r, !done_r, "divider done held more than one cycle")
  `CBMA_ASSERT_IMP(a_div_no_restart, start, !busy_r, "divider started while busy")
  `CBMA_ASSERT_IMP(a_div_step_range, busy_r, step_r < STEP_W'(NUM_W), "divider step out of range")

endmodule
